// ===== rtl/core/mahsd_pkg.sv =====
// Shared types, constants and lookup tables for the MPEG audio header sync decoder.
// No dependencies; imported by every module of the block.
package mahsd_pkg;

    // Longest buffer that is scanned; later bytes of a buffer are not scanned but still yield a queue request.
    localparam longint BUFFER_BYTES = 65536;
    localparam int     SEEN_W       = $clog2(BUFFER_BYTES + 1);

    // Front-to-back queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Frame size divider: kbps*144000 / (rate << lsf), quotient below 2048.
    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 17;
    localparam int QUO_W      = 11;
    localparam int DSH_W      = DIVISOR_W + QUO_W - 1;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int KBPS_W     = 9;
    localparam int BYTE_SCALE = 144000;

    // Header patterns that are rejected.
    localparam logic [31:0] RIFF_WORD  = 32'h5249_4646;
    localparam logic [31:0] ID3_WORD   = 32'h4944_3320;
    localparam logic [31:0] ID3_MASK   = 32'hffff_ff00;
    localparam logic [31:0] SYNC_MASK  = 32'hffe0_0000;
    localparam logic [31:0] FFFE_MASK  = 32'hffff_0000;
    localparam logic [31:0] FFFE_WORD  = 32'hfffe_0000;

    typedef enum logic [1:0] {
        ST_SEARCH = 2'd0,
        ST_FOUND  = 2'd1,
        ST_NONE   = 2'd2
    } status_t;

    // One request from the front to the back.
    typedef struct packed {
        status_t     status;
        logic [15:0] header_offset;
        logic [31:0] header_word;
    } q_entry_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] header_offset;
        logic [31:0] header_word;
        logic        low_rate_flag;
        logic        mpeg25_flag;
        logic [1:0]  channel_mode;
        logic        crc_present;
        logic [5:0]  side_info_size;
        logic [3:0]  kbps_index;
        logic [3:0]  sample_rate_index;
        logic        padding;
        logic [10:0] frame_size;
    } res_t;

    function automatic logic header_ok(input logic [31:0] w);
        logic ok;
        ok = 1'b1;
        if (w == RIFF_WORD)                         ok = 1'b0;
        if ((w & ID3_MASK) == ID3_WORD)             ok = 1'b0;
        if ((w & SYNC_MASK) != SYNC_MASK)           ok = 1'b0;
        if (w[18:17] == 2'd0)                       ok = 1'b0;
        if (w[15:12] == 4'd0 || w[15:12] == 4'd15)  ok = 1'b0;
        if (w[11:10] == 2'd3)                       ok = 1'b0;
        // version bit 19 set, layer I, protection bit set (no CRC)
        if (w[19] && w[18:17] == 2'd3 && w[16])     ok = 1'b0;
        if ((w & FFFE_MASK) == FFFE_WORD)           ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic lsf, input logic [3:0] br);
        logic [KBPS_W-1:0] k;
        if (!lsf) begin
            case (br)
                4'd1:    k = 9'd32;
                4'd2:    k = 9'd40;
                4'd3:    k = 9'd48;
                4'd4:    k = 9'd56;
                4'd5:    k = 9'd64;
                4'd6:    k = 9'd80;
                4'd7:    k = 9'd96;
                4'd8:    k = 9'd112;
                4'd9:    k = 9'd128;
                4'd10:   k = 9'd160;
                4'd11:   k = 9'd192;
                4'd12:   k = 9'd224;
                4'd13:   k = 9'd256;
                4'd14:   k = 9'd320;
                default: k = 9'd0;
            endcase
        end else begin
            case (br)
                4'd1:    k = 9'd8;
                4'd2:    k = 9'd16;
                4'd3:    k = 9'd24;
                4'd4:    k = 9'd32;
                4'd5:    k = 9'd40;
                4'd6:    k = 9'd48;
                4'd7:    k = 9'd56;
                4'd8:    k = 9'd64;
                4'd9:    k = 9'd80;
                4'd10:   k = 9'd96;
                4'd11:   k = 9'd112;
                4'd12:   k = 9'd128;
                4'd13:   k = 9'd144;
                4'd14:   k = 9'd160;
                default: k = 9'd0;
            endcase
        end
        return k;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [3:0] sr);
        logic [15:0] r;
        case (sr)
            4'd0:    r = 16'd44100;
            4'd1:    r = 16'd48000;
            4'd2:    r = 16'd32000;
            4'd3:    r = 16'd22050;
            4'd4:    r = 16'd24000;
            4'd5:    r = 16'd16000;
            4'd6:    r = 16'd11025;
            4'd7:    r = 16'd12000;
            default: r = 16'd8000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/mahsd_front.sv =====
// Front end: byte window, buffer count and header sync test; one queue request per byte.
// Depends on mahsd_pkg.
module mahsd_front import mahsd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       s_tlast,
    output logic       q_push,
    output q_entry_t   q_entry,
    input  logic       q_full
);

    logic [23:0]       window_reg, window_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              done_reg, done_next;

    logic [23:0]       win_eff;
    logic [SEEN_W-1:0] seen_eff;
    logic              done_eff;
    logic              in_range;
    logic              found;
    logic [31:0]       word;
    logic [SEEN_W-1:0] offs;
    logic              accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb begin
        // a first byte starts from a cleared state
        win_eff  = s_tuser ? 24'd0 : window_reg;
        seen_eff = s_tuser ? '0 : seen_reg;
        done_eff = s_tuser ? 1'b0 : done_reg;
        in_range = seen_eff < SEEN_W'(BUFFER_BYTES);
        word     = {win_eff, s_tdata};
        found    = in_range && !done_eff && (seen_eff >= SEEN_W'(3)) && header_ok(word);
        offs     = seen_eff - SEEN_W'(3);

        window_next = win_eff;
        seen_next   = seen_eff;
        done_next   = done_eff || found;
        if (in_range) begin
            window_next = word[23:0];
            seen_next   = seen_eff + SEEN_W'(1);
        end
        if (s_tlast) begin
            window_next = 24'd0;
            seen_next   = '0;
            done_next   = 1'b0;
        end

        q_entry.header_offset = offs[15:0];
        q_entry.header_word   = word;
        if (found) begin
            q_entry.status = ST_FOUND;
        end else if (s_tlast && !done_eff) begin
            q_entry.status = ST_NONE;
        end else begin
            q_entry.status = ST_SEARCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= 24'd0;
            seen_reg   <= '0;
            done_reg   <= 1'b0;
        end else if (accept) begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
            done_reg   <= done_next;
        end
    end

    a_found_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && found && !s_tlast) |=> done_reg)
        else $error("header found but done flag not set");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && done_reg && !s_tuser) |-> (q_entry.status != ST_FOUND))
        else $error("second header reported in one buffer");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (seen_reg == '0 && !done_reg))
        else $error("buffer state not cleared after last byte");

endmodule

// ===== rtl/core/mahsd_fifo.sv =====
// Short request queue between front and back ends.
// Depends on mahsd_pkg.
module mahsd_fifo import mahsd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     empty
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count lost a push");

endmodule

// ===== rtl/core/mahsd_back.sv =====
// Back end: field decode, serial frame size divider and output register.
// Depends on mahsd_pkg.
module mahsd_back import mahsd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  q_entry_t q_data,
    input  logic     q_empty,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     out_res
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_FIN  = 3'b100
    } bstate_t;

    bstate_t               state_reg;
    logic                  out_valid_reg;
    res_t                  out_res_reg;
    res_t                  hold_reg;
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DSH_W-1:0]      dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [STEP_W-1:0]     step_reg;

    logic                  out_free;
    logic [31:0]           w;
    res_t                  dec;
    logic [3:0]            sr_raw;
    logic [5:0]            side_base;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DSH_W-1:0]      rem_ext;
    logic                  take;
    logic [QUO_W:0]        fsz_wide;
    res_t                  idle_res;
    res_t                  fin_res;

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty && out_free;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // field decode of the queued word
    always_comb begin
        w   = q_data.header_word;
        dec = '0;
        dec.status        = q_data.status;
        dec.header_offset = q_data.header_offset;
        dec.header_word   = w;
        dec.mpeg25_flag   = !w[20];
        dec.low_rate_flag = w[20] ? !w[19] : 1'b1;
        dec.channel_mode  = w[7:6];
        dec.crc_present   = !w[16];
        if (dec.low_rate_flag) begin
            side_base = (w[7:6] != 2'd3) ? 6'd17 : 6'd9;
        end else begin
            side_base = (w[7:6] != 2'd3) ? 6'd32 : 6'd17;
        end
        dec.side_info_size = side_base + (dec.crc_present ? 6'd2 : 6'd0);
        dec.kbps_index     = w[15:12];
        if (dec.mpeg25_flag) begin
            sr_raw = 4'd6 + {2'b00, w[11:10]};
        end else begin
            sr_raw = {2'b00, w[11:10]} + (dec.low_rate_flag ? 4'd3 : 4'd0);
        end
        dec.sample_rate_index = (sr_raw > 4'd8) ? 4'd8 : sr_raw;
        dec.padding           = w[9];
        divisor  = DIVISOR_W'(rate_lookup(dec.sample_rate_index)) << dec.low_rate_flag;
        dividend = DIVIDEND_W'(kbps_lookup(dec.low_rate_flag, w[15:12]) * BYTE_SCALE);
    end

    assign rem_ext  = DSH_W'(rem_reg);
    assign take     = rem_ext >= dsh_reg;
    assign fsz_wide = {1'b0, quo_reg} + (QUO_W+1)'(hold_reg.padding) - (QUO_W+1)'(4);

    // result words for a plain request and for a finished header
    always_comb begin
        idle_res           = '0;
        idle_res.status    = q_data.status;
        fin_res            = hold_reg;
        fin_res.frame_size = fsz_wide[QUO_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        if (q_data.status == ST_FOUND) begin
                            state_reg <= B_DIV;
                            if (out_ready) begin
                                out_valid_reg <= 1'b0;
                            end
                        end else begin
                            out_valid_reg <= 1'b1;
                        end
                    end else if (out_ready) begin
                        out_valid_reg <= 1'b0;
                    end
                end
                B_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= B_FIN;
                    end
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        state_reg     <= B_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    if (q_data.status == ST_FOUND) begin
                        hold_reg <= dec;
                        rem_reg  <= dividend;
                        dsh_reg  <= {divisor, (QUO_W-1)'(0)};
                        quo_reg  <= '0;
                        step_reg <= STEP_W'(QUO_W - 1);
                    end else begin
                        out_res_reg <= idle_res;
                    end
                end
            end
            B_DIV: begin
                if (take) begin
                    rem_reg <= DIVIDEND_W'(rem_ext - dsh_reg);
                end
                quo_reg  <= {quo_reg[QUO_W-2:0], take};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            B_FIN: begin
                if (out_free) begin
                    out_res_reg <= fin_res;
                end
            end
            default: ;
        endcase
    end

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.status != ST_FOUND) |->
            (out_res_reg.header_word == 32'd0 && out_res_reg.frame_size == '0))
        else $error("fields not cleared on a non-header result");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != B_IDLE) |-> !q_pop)
        else $error("queue popped while divider busy");

    a_fin_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV && step_reg == '0) |=> (state_reg == B_FIN))
        else $error("divider did not finish after last step");

endmodule

// ===== rtl/core/mpeg_audio_header_sync_decode.sv =====
// Top level of the MPEG audio header sync decoder: front end, request queue, back end.
// Depends on mahsd_pkg, mahsd_front, mahsd_fifo, mahsd_back.
//
// Channel   Dir  tdata                        tuser           tlast
// s_        in   data_byte[7:0]               first_byte      last_byte
// m_        out  header fields, see m_tdata   status[1:0]     (none)
//
// Flow: every accepted byte yields one result. A byte that is not a found
// header skips the divider. A found header passes the back end in steps:
// a decode/load step, 11 restoring divide steps for the frame size and a
// finish step; the front keeps taking bytes meanwhile until the 4-entry
// request queue fills. Reset (aresetn low, synchronous) clears the window,
// byte count, done flag, queue and output valid. Either side may stall.
module mpeg_audio_header_sync_decode import mahsd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] header_offset, [47:16] header_word, [48] low_rate_flag,
    // [49] mpeg25_flag, [51:50] channel_mode, [52] crc_present,
    // [58:53] side_info_size, [62:59] kbps_index, [66:63] sample_rate_index,
    // [67] padding, [78:68] frame_size, [79] zero
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic     q_push, q_full, q_pop, q_empty;
    q_entry_t q_in, q_out;
    res_t     res;

    mahsd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    // decouples byte scanning from the serial frame size divide
    mahsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    mahsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_data    (q_out),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack result fields, from the top bit down to header_offset at bit 0
    assign m_tuser = res.status;
    assign m_tdata = {1'b0,
                      res.frame_size,
                      res.padding,
                      res.sample_rate_index,
                      res.kbps_index,
                      res.side_info_size,
                      res.crc_present,
                      res.channel_mode,
                      res.mpeg25_flag,
                      res.low_rate_flag,
                      res.header_word,
                      res.header_offset};

endmodule
